FILE: sv/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// Types, constants and field helpers for the transaction byte parser.
// ----------------------------------------------------------------------------
`default_nettype none
package tsp_pkg;

  localparam int unsigned MaxBufferBytes = 4194304;
  localparam int unsigned LenW  = 23;
  localparam int unsigned IdxW  = 22;
  localparam int unsigned ValW  = 64;
  localparam int unsigned BifW  = 6;
  localparam int unsigned CwW   = 4;

  localparam logic [LenW-1:0] MinTxBytes = LenW'(10);
  localparam logic [LenW-1:0] MaxLen     = LenW'(MaxBufferBytes);
  localparam logic [BifW-1:0] HashBytes  = BifW'(32);
  localparam logic [BifW-1:0] Fix4       = BifW'(4);
  localparam logic [BifW-1:0] Fix8       = BifW'(8);

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 120;

  typedef enum logic [4:0] {
    PH_VERSION    = 5'd0,
    PH_MARKER     = 5'd1,
    PH_FLAG       = 5'd2,
    PH_IN_COUNT   = 5'd3,
    PH_PREV_ID    = 5'd4,
    PH_PREV_INDEX = 5'd5,
    PH_SIG_LEN    = 5'd6,
    PH_SIG_BYTE   = 5'd7,
    PH_SEQUENCE   = 5'd8,
    PH_OUT_COUNT  = 5'd9,
    PH_AMOUNT     = 5'd10,
    PH_PK_LEN     = 5'd11,
    PH_PK_BYTE    = 5'd12,
    PH_WIT_COUNT  = 5'd13,
    PH_ITEM_LEN   = 5'd14,
    PH_ITEM_BYTE  = 5'd15,
    PH_LOCKTIME   = 5'd16,
    PH_AFTER      = 5'd17
  } phase_e;

  typedef struct packed {
    logic [ValW-1:0] acc;
    logic [BifW-1:0] bif;
    logic [CwW-1:0]  cw;
    logic            done;
  } feed_t;

  typedef struct packed {
    logic [LenW-1:0] consumed;
    logic            error;
    logic            done_res;
    logic            segwit_seen;
    logic [ValW-1:0] value_out;
    logic            field_end;
    logic [IdxW-1:0] entry_index;
    phase_e          part;
  } result_t;

  // Little-endian fixed field of n bytes.
  function automatic feed_t feed_fixed(logic [ValW-1:0] acc, logic [BifW-1:0] bif,
                                       logic [CwW-1:0] cw, logic [7:0] b,
                                       logic [BifW-1:0] n);
    feed_t r;
    r.acc = (bif == '0) ? '0 : acc;
    r.acc[bif[2:0]*8 +: 8] = r.acc[bif[2:0]*8 +: 8] | b;
    r.bif = bif + BifW'(1);
    r.cw = cw;
    r.done = 1'b0;
    if (r.bif >= n) begin
      r.bif = '0;
      r.done = 1'b1;
    end
    return r;
  endfunction

  // Compact-size field, no canonical check.
  function automatic feed_t feed_compact(logic [ValW-1:0] acc, logic [BifW-1:0] bif,
                                         logic [CwW-1:0] cw, logic [7:0] b);
    feed_t r;
    logic [BifW-1:0] k;
    r.acc = acc;
    r.bif = bif;
    r.cw = cw;
    r.done = 1'b0;
    k = bif - BifW'(1);
    if (bif == '0) begin
      r.acc = '0;
      if (b < 8'hFD) begin
        r.acc[7:0] = b;
        r.done = 1'b1;
      end else begin
        r.cw = (b == 8'hFD) ? CwW'(2) : (b == 8'hFE) ? CwW'(4) : CwW'(8);
        r.bif = BifW'(1);
      end
    end else begin
      r.acc[k[2:0]*8 +: 8] = r.acc[k[2:0]*8 +: 8] | b;
      r.bif = bif + BifW'(1);
      if (bif >= BifW'(cw)) begin
        r.bif = '0;
        r.cw = '0;
        r.done = 1'b1;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/tsp_core.sv
// ----------------------------------------------------------------------------
// tsp_core
// Parse state registers and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
`default_nettype none
module tsp_core import tsp_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            first_i,
  input  wire logic [LenW-1:0] blen_i,
  input  wire logic            exact_i,
  output result_t              res_o
);

  phase_e          ph_q, ph_d;
  logic [BifW-1:0] bif_q, bif_d;
  logic [ValW-1:0] acc_q, acc_d;
  logic [CwW-1:0]  cw_q, cw_d;
  logic [LenW-1:0] off_q, off_d, tot_q, tot_d, blob_q, blob_d;
  logic [IdxW-1:0] in_tot_q, in_tot_d, cnt_q, cnt_d, ent_tot_q, ent_tot_d;
  logic [IdxW-1:0] item_q, item_d, item_tot_q, item_tot_d;
  logic            wit_q, wit_d, err_q, err_d, done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_VERSION;
      bif_q <= '0; acc_q <= '0; cw_q <= '0; off_q <= '0; tot_q <= '0;
      blob_q <= '0; in_tot_q <= '0; cnt_q <= '0; ent_tot_q <= '0;
      item_q <= '0; item_tot_q <= '0;
      wit_q <= 1'b0; err_q <= 1'b0; done_q <= 1'b0;
    end else if (step_i) begin
      ph_q <= ph_d;
      bif_q <= bif_d; acc_q <= acc_d; cw_q <= cw_d; off_q <= off_d; tot_q <= tot_d;
      blob_q <= blob_d; in_tot_q <= in_tot_d; cnt_q <= cnt_d; ent_tot_q <= ent_tot_d;
      item_q <= item_d; item_tot_q <= item_tot_d;
      wit_q <= wit_d; err_q <= err_d; done_q <= done_d;
    end
  end

  always_comb begin
    feed_t           f;
    logic [LenW-1:0] remain;
    logic [LenW-1:0] off1;
    logic            fe;
    logic [ValW-1:0] val;
    phase_e          part;
    logic [IdxW-1:0] idx;

    ph_d = ph_q; bif_d = bif_q; acc_d = acc_q; cw_d = cw_q; off_d = off_q;
    tot_d = tot_q; blob_d = blob_q; in_tot_d = in_tot_q; cnt_d = cnt_q;
    ent_tot_d = ent_tot_q; item_d = item_q; item_tot_d = item_tot_q;
    wit_d = wit_q; err_d = err_q; done_d = done_q;
    fe = 1'b0;
    val = '0;
    f = '0;

    if (first_i) begin
      ph_d = PH_VERSION;
      bif_d = '0; acc_d = '0; cw_d = '0; off_d = '0; blob_d = '0;
      in_tot_d = '0; cnt_d = '0; ent_tot_d = '0; item_d = '0; item_tot_d = '0;
      wit_d = 1'b0; done_d = 1'b0;
      tot_d = blen_i;
      err_d = (blen_i < MinTxBytes) || (blen_i > MaxLen);
    end
    // A non-zero byte after the version is already the input count.
    if (!err_d && !done_d && ph_d == PH_MARKER && byte_i != 8'h00) ph_d = PH_IN_COUNT;

    part = done_d ? PH_AFTER : ph_d;
    idx = '0;
    if (!done_d) begin
      if ((ph_d >= PH_PREV_ID && ph_d <= PH_SEQUENCE) ||
          (ph_d >= PH_AMOUNT && ph_d <= PH_WIT_COUNT)) idx = cnt_d;
      else if (ph_d == PH_ITEM_LEN || ph_d == PH_ITEM_BYTE) idx = item_d;
    end

    off1 = off_d + LenW'(1);
    remain = (off1 <= tot_d) ? (tot_d - off1) : '0;

    if (err_d) begin
      // frozen
    end else if (done_d) begin
      if (exact_i) err_d = 1'b1;
    end else if (off_d >= tot_d) begin
      err_d = 1'b1;
    end else begin
      case (ph_d)
        PH_VERSION, PH_PREV_INDEX, PH_SEQUENCE, PH_AMOUNT, PH_LOCKTIME: begin
          f = feed_fixed(acc_d, bif_d, cw_d, byte_i, (ph_d == PH_AMOUNT) ? Fix8 : Fix4);
          acc_d = f.acc;
          bif_d = f.bif;
          if (f.done) begin
            fe = 1'b1;
            val = f.acc;
            case (ph_d)
              PH_VERSION:    ph_d = PH_MARKER;
              PH_PREV_INDEX: ph_d = PH_SIG_LEN;
              PH_AMOUNT:     ph_d = PH_PK_LEN;
              PH_SEQUENCE: begin
                cnt_d = cnt_d + IdxW'(1);
                ph_d = (cnt_d < in_tot_d) ? PH_PREV_ID : PH_OUT_COUNT;
              end
              default: begin
                if (exact_i && off1 != tot_d) err_d = 1'b1;
                else begin
                  done_d = 1'b1;
                  ph_d = PH_AFTER;
                end
              end
            endcase
          end
        end
        PH_MARKER: begin
          fe = 1'b1;
          ph_d = PH_FLAG;
        end
        PH_FLAG: begin
          fe = 1'b1;
          val = {56'd0, byte_i};
          if (!byte_i[0]) err_d = 1'b1;
          else begin
            wit_d = 1'b1;
            ph_d = PH_IN_COUNT;
          end
        end
        PH_IN_COUNT, PH_OUT_COUNT, PH_WIT_COUNT: begin
          f = feed_compact(acc_d, bif_d, cw_d, byte_i);
          acc_d = f.acc; bif_d = f.bif; cw_d = f.cw;
          if (f.done) begin
            fe = 1'b1;
            val = f.acc;
            if (f.acc > {41'd0, remain}) err_d = 1'b1;
            else if (ph_d == PH_IN_COUNT) begin
              in_tot_d = f.acc[IdxW-1:0];
              cnt_d = '0;
              ph_d = (f.acc != '0) ? PH_PREV_ID : PH_OUT_COUNT;
            end else if (ph_d == PH_OUT_COUNT) begin
              ent_tot_d = f.acc[IdxW-1:0];
              cnt_d = '0;
              if (f.acc != '0) ph_d = PH_AMOUNT;
              else if (wit_d && in_tot_d != '0) ph_d = PH_WIT_COUNT;
              else ph_d = PH_LOCKTIME;
            end else begin
              item_tot_d = f.acc[IdxW-1:0];
              item_d = '0;
              if (f.acc != '0) ph_d = PH_ITEM_LEN;
              else begin
                cnt_d = cnt_d + IdxW'(1);
                ph_d = (cnt_d < in_tot_d) ? PH_WIT_COUNT : PH_LOCKTIME;
              end
            end
          end
        end
        PH_PREV_ID: begin
          bif_d = bif_d + BifW'(1);
          if (bif_d >= HashBytes) begin
            bif_d = '0;
            ph_d = PH_PREV_INDEX;
          end
        end
        PH_SIG_LEN, PH_PK_LEN, PH_ITEM_LEN: begin
          f = feed_compact(acc_d, bif_d, cw_d, byte_i);
          acc_d = f.acc; bif_d = f.bif; cw_d = f.cw;
          if (f.done) begin
            fe = 1'b1;
            val = f.acc;
            if (f.acc > {41'd0, tot_d}) err_d = 1'b1;
            else begin
              blob_d = f.acc[LenW-1:0];
              if (f.acc != '0) begin
                ph_d = (ph_d == PH_SIG_LEN) ? PH_SIG_BYTE :
                       (ph_d == PH_PK_LEN) ? PH_PK_BYTE : PH_ITEM_BYTE;
              end else if (ph_d == PH_SIG_LEN) begin
                ph_d = PH_SEQUENCE;
              end else if (ph_d == PH_PK_LEN) begin
                cnt_d = cnt_d + IdxW'(1);
                if (cnt_d < ent_tot_d) ph_d = PH_AMOUNT;
                else if (wit_d && in_tot_d != '0) begin
                  cnt_d = '0;
                  ph_d = PH_WIT_COUNT;
                end else ph_d = PH_LOCKTIME;
              end else begin
                item_d = item_d + IdxW'(1);
                if (item_d < item_tot_d) ph_d = PH_ITEM_LEN;
                else begin
                  cnt_d = cnt_d + IdxW'(1);
                  ph_d = (cnt_d < in_tot_d) ? PH_WIT_COUNT : PH_LOCKTIME;
                end
              end
            end
          end
        end
        PH_SIG_BYTE, PH_PK_BYTE, PH_ITEM_BYTE: begin
          if (blob_d != '0) blob_d = blob_d - LenW'(1);
          if (blob_d == '0) begin
            if (ph_d == PH_SIG_BYTE) ph_d = PH_SEQUENCE;
            else if (ph_d == PH_PK_BYTE) begin
              cnt_d = cnt_d + IdxW'(1);
              if (cnt_d < ent_tot_d) ph_d = PH_AMOUNT;
              else if (wit_d && in_tot_d != '0) begin
                cnt_d = '0;
                ph_d = PH_WIT_COUNT;
              end else ph_d = PH_LOCKTIME;
            end else begin
              item_d = item_d + IdxW'(1);
              if (item_d < item_tot_d) ph_d = PH_ITEM_LEN;
              else begin
                cnt_d = cnt_d + IdxW'(1);
                ph_d = (cnt_d < in_tot_d) ? PH_WIT_COUNT : PH_LOCKTIME;
              end
            end
          end
        end
        default: err_d = 1'b1;
      endcase
      if (!err_d) begin
        off_d = off1;
        if (!done_d && off_d >= tot_d) err_d = 1'b1;
      end
    end

    if (err_d) begin
      fe = 1'b0;
      val = '0;
    end
    res_o.part        = part;
    res_o.entry_index = idx;
    res_o.field_end   = fe;
    res_o.value_out   = val;
    res_o.segwit_seen = wit_d;
    res_o.done_res    = done_d && !err_d;
    res_o.error       = err_d;
    res_o.consumed    = (done_d && !err_d) ? off_d : '0;
  end

endmodule
`default_nettype wire

FILE: sv/tx_serialization_parser.sv
// ----------------------------------------------------------------------------
// tx_serialization_parser
// Byte-serial parser for a serialized transaction, one result per byte.
// ----------------------------------------------------------------------------
// channel  | direction | handshake                  | payload
// s_axis   | in        | s_axis_tvalid/s_axis_tready | byte_in, buffer_len; tuser first
// m_axis   | out       | m_axis_tvalid/m_axis_tready | one result per input byte
// cfg      | in        | cfg_valid_i/cfg_ready_o    | exact_length
//
// One byte per cycle while the output is not stalled; the parse state and the
// output register both load at the accepting edge, so a result shows in the
// cycle after its byte. Input is taken while the output register is empty or
// being drained. Reset clears the parse state and sets exact_length to 1.
`default_nettype none
module tx_serialization_parser import tsp_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // byte_in[7:0], buffer_len[30:8]
  input  wire logic                s_axis_tuser,  // first
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // part, entry_index, field_end, value_out, segwit seen, done_res, error, consumed
  output logic [OutDataW-1:0]      m_axis_tdata,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_data_i
);

  logic    exact_q;
  logic    out_vld_q;
  result_t res_q;
  result_t res;
  logic    step;

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign step = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  tsp_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (s_axis_tdata[7:0]),
    .first_i (s_axis_tuser),
    .blen_i  (s_axis_tdata[30:8]),
    .exact_i (exact_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exact_q <= 1'b1;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) exact_q <= cfg_data_i;
      if (step) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) res_q <= res;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = {2'b00, res_q};

endmodule
`default_nettype wire

FILE: sv/tsp_checker.sv
// ----------------------------------------------------------------------------
// tsp_checker
// Port-level checks on the parser result stream.
// ----------------------------------------------------------------------------
`default_nettype none
module tsp_checker import tsp_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata
);

  // Stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // An accepted byte always yields a result next cycle.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted byte produced no result");

  // An error suppresses the decoded value and completion.
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[94] |->
      !m_axis_tdata[27] && m_axis_tdata[91:28] == '0 && !m_axis_tdata[93])
    else $error("error with field value or done");

  // Consumed is reported only with done.
  a_cons: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[93] |-> m_axis_tdata[117:95] == '0)
    else $error("consumed without done");

endmodule

bind tx_serialization_parser tsp_checker u_tsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

FILE: verif/tx_serialization_parser_tb.sv
// ----------------------------------------------------------------------------
// tx_serialization_parser_tb
// Streams serialized transactions byte by byte through the parser and checks
// every result against a behavioral parser model, with random idling on the
// input and output streams and exact_length changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tx_serialization_parser_tb;
  import tsp_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic            first;
    logic [LenW-1:0] blen;
    logic [7:0]      b;
  } byte_item_t;

  typedef struct {
    byte_item_t it;
    logic       chk;   // typed-in expectation present
    phase_e     part;
    logic       err;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_data_i = 1'b0;

  tx_serialization_parser u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---- parser model state ----
  logic            m_exact;
  phase_e          m_ph;
  int unsigned     m_bif, m_cw, m_off, m_tot;
  int unsigned     m_in_tot, m_cnt, m_ent_tot, m_icnt, m_itot, m_blob;
  logic [63:0]     m_acc;
  logic            m_wit, m_err, m_done;

  result_t     parse_results[$];
  row_t        typed_rows[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic void clear_parse();
    m_ph = PH_VERSION;
    m_bif = 0; m_cw = 0; m_off = 0; m_tot = 0;
    m_in_tot = 0; m_cnt = 0; m_ent_tot = 0; m_icnt = 0; m_itot = 0; m_blob = 0;
    m_acc = '0; m_wit = 0; m_err = 0; m_done = 0;
  endfunction

  function automatic bit fixed_done(logic [7:0] b, int unsigned n);
    if (m_bif == 0) m_acc = '0;
    m_acc |= 64'(b) << (8 * (m_bif & 7));
    m_bif++;
    if (m_bif >= n) begin
      m_bif = 0;
      return 1;
    end
    return 0;
  endfunction

  function automatic bit compact_done(logic [7:0] b);
    if (m_bif == 0) begin
      m_acc = '0;
      if (b < 8'hFD) begin
        m_acc = 64'(b);
        return 1;
      end
      m_cw = (b == 8'hFD) ? 2 : (b == 8'hFE) ? 4 : 8;
      m_bif = 1;
      return 0;
    end
    m_acc |= 64'(b) << (8 * ((m_bif - 1) & 7));
    m_bif++;
    if (m_bif - 1 >= m_cw) begin
      m_bif = 0; m_cw = 0;
      return 1;
    end
    return 0;
  endfunction

  function automatic void after_outputs();
    if (m_wit && m_in_tot != 0) begin
      m_cnt = 0; m_ph = PH_WIT_COUNT;
    end else m_ph = PH_LOCKTIME;
  endfunction

  function automatic void next_wit_input();
    m_cnt++;
    m_ph = (m_cnt < m_in_tot) ? PH_WIT_COUNT : PH_LOCKTIME;
  endfunction

  function automatic void next_output();
    m_cnt++;
    if (m_cnt < m_ent_tot) m_ph = PH_AMOUNT; else after_outputs();
  endfunction

  function automatic void next_item();
    m_icnt++;
    if (m_icnt < m_itot) m_ph = PH_ITEM_LEN; else next_wit_input();
  endfunction

  function automatic result_t parse_byte(byte_item_t it);
    result_t r;
    phase_e  p;
    logic    fe;
    logic [63:0] v;
    logic [63:0] rem;
    fe = 0; v = '0;
    if (it.first) begin
      clear_parse();
      m_tot = 32'(it.blen);
      if (it.blen < MinTxBytes || it.blen > MaxLen) m_err = 1;
    end
    if (!m_err && !m_done && m_ph == PH_MARKER && it.b != 8'h00) m_ph = PH_IN_COUNT;
    r = '0;
    r.part = m_done ? PH_AFTER : m_ph;
    p = m_ph;
    if (!m_done) begin
      if ((p >= PH_PREV_ID && p <= PH_SEQUENCE) || (p >= PH_AMOUNT && p <= PH_WIT_COUNT))
        r.entry_index = IdxW'(m_cnt);
      else if (p == PH_ITEM_LEN || p == PH_ITEM_BYTE) r.entry_index = IdxW'(m_icnt);
    end
    rem = (m_off + 1 <= m_tot) ? 64'(m_tot - m_off - 1) : 64'd0;
    if (m_err) begin
    end else if (m_done) begin
      if (m_exact) m_err = 1;
    end else if (m_off >= m_tot) begin
      m_err = 1;
    end else begin
      case (m_ph)
        PH_VERSION: if (fixed_done(it.b, 4)) begin
          fe = 1; v = m_acc; m_ph = PH_MARKER;
        end
        PH_MARKER: begin
          fe = 1; m_ph = PH_FLAG;
        end
        PH_FLAG: begin
          fe = 1; v = 64'(it.b);
          if (!it.b[0]) m_err = 1;
          else begin
            m_wit = 1; m_ph = PH_IN_COUNT;
          end
        end
        PH_IN_COUNT, PH_OUT_COUNT, PH_WIT_COUNT: if (compact_done(it.b)) begin
          fe = 1; v = m_acc;
          if (v > rem) m_err = 1;
          else if (m_ph == PH_IN_COUNT) begin
            m_in_tot = 32'(v); m_cnt = 0;
            m_ph = (v != 0) ? PH_PREV_ID : PH_OUT_COUNT;
          end else if (m_ph == PH_OUT_COUNT) begin
            m_ent_tot = 32'(v); m_cnt = 0;
            if (v != 0) m_ph = PH_AMOUNT; else after_outputs();
          end else begin
            m_itot = 32'(v); m_icnt = 0;
            if (v != 0) m_ph = PH_ITEM_LEN; else next_wit_input();
          end
        end
        PH_PREV_ID: begin
          m_bif++;
          if (m_bif >= 32) begin
            m_bif = 0; m_ph = PH_PREV_INDEX;
          end
        end
        PH_PREV_INDEX: if (fixed_done(it.b, 4)) begin
          fe = 1; v = m_acc; m_ph = PH_SIG_LEN;
        end
        PH_SIG_LEN, PH_PK_LEN, PH_ITEM_LEN: if (compact_done(it.b)) begin
          fe = 1; v = m_acc;
          if (v > 64'(m_tot)) m_err = 1;
          else begin
            m_blob = 32'(v);
            if (m_ph == PH_SIG_LEN) m_ph = (v != 0) ? PH_SIG_BYTE : PH_SEQUENCE;
            else if (m_ph == PH_PK_LEN) begin
              if (v != 0) m_ph = PH_PK_BYTE; else next_output();
            end else begin
              if (v != 0) m_ph = PH_ITEM_BYTE; else next_item();
            end
          end
        end
        PH_SIG_BYTE, PH_PK_BYTE, PH_ITEM_BYTE: begin
          if (m_blob != 0) m_blob--;
          if (m_blob == 0) begin
            if (m_ph == PH_SIG_BYTE) m_ph = PH_SEQUENCE;
            else if (m_ph == PH_PK_BYTE) next_output();
            else next_item();
          end
        end
        PH_SEQUENCE: if (fixed_done(it.b, 4)) begin
          fe = 1; v = m_acc;
          m_cnt++;
          m_ph = (m_cnt < m_in_tot) ? PH_PREV_ID : PH_OUT_COUNT;
        end
        PH_AMOUNT: if (fixed_done(it.b, 8)) begin
          fe = 1; v = m_acc; m_ph = PH_PK_LEN;
        end
        PH_LOCKTIME: if (fixed_done(it.b, 4)) begin
          fe = 1; v = m_acc;
          if (m_exact && m_off + 1 != m_tot) m_err = 1;
          else begin
            m_done = 1; m_ph = PH_AFTER;
          end
        end
        default: m_err = 1;
      endcase
      if (!m_err) begin
        m_off++;
        if (!m_done && m_off >= m_tot) m_err = 1;
      end
    end
    if (m_err) begin
      fe = 0; v = '0;
    end
    r.field_end = fe;
    r.value_out = v;
    r.segwit_seen = m_wit;
    r.done_res = m_done && !m_err;
    r.error = m_err;
    r.consumed = r.done_res ? LenW'(m_off) : '0;
    return r;
  endfunction

  // ---- stimulus store ----
  byte_item_t tx_bytes[$];
  row_t       dir_rows[$];

  function automatic void push_byte(logic [7:0] b);
    byte_item_t it;
    it.first = (tx_bytes.size() == 0);
    it.blen = '0;
    it.b = b;
    tx_bytes.insert(tx_bytes.size(), it);
  endfunction

  function automatic void push_le(logic [63:0] v, int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_byte(v[8*i +: 8]);
  endfunction

  function automatic void push_compact(logic [63:0] v, int unsigned form);
    if (form == 0) push_byte(v[7:0]);
    else if (form == 1) begin
      push_byte(8'hFD); push_le(v, 2);
    end else if (form == 2) begin
      push_byte(8'hFE); push_le(v, 4);
    end else begin
      push_byte(8'hFF); push_le(v, 8);
    end
  endfunction

  function automatic int unsigned rand_form(logic [63:0] v);
    if (v >= 64'hFD) return $urandom_range(1, 3);
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  function automatic void push_blob(int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_byte(8'($urandom));
  endfunction

  // Well-formed transaction with random content; trailing bytes beyond it.
  function automatic void build_tx(bit segwit, int unsigned trail);
    int unsigned nin, nout, n, k;
    tx_bytes.delete();
    push_le({$urandom, $urandom}, 4);
    if (segwit) begin
      push_byte(8'h00);
      push_byte(8'($urandom) | 8'h01);
    end
    nin = $urandom_range(0, 2);
    push_compact(nin, rand_form(nin));
    for (int unsigned i = 0; i < nin; i++) begin
      push_blob(32);
      push_le($urandom, 4);
      n = $urandom_range(0, 4);
      push_compact(n, rand_form(n));
      push_blob(n);
      push_le($urandom, 4);
    end
    nout = $urandom_range(0, 2);
    push_compact(nout, rand_form(nout));
    for (int unsigned i = 0; i < nout; i++) begin
      push_le({$urandom, $urandom}, 8);
      n = $urandom_range(0, 4);
      push_compact(n, rand_form(n));
      push_blob(n);
    end
    if (segwit) for (int unsigned i = 0; i < nin; i++) begin
      k = $urandom_range(0, 2);
      push_compact(k, rand_form(k));
      for (int unsigned j = 0; j < k; j++) begin
        n = $urandom_range(0, 3);
        push_compact(n, rand_form(n));
        push_blob(n);
      end
    end
    push_le($urandom, 4);
    push_blob(trail);
    tx_bytes[0].blen = LenW'(tx_bytes.size());
  endfunction

  // ---- input driver ----
  task automatic send_byte(byte_item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= InDataW'({it.blen, it.b});
    s_axis_tuser <= it.first;
    parse_results.insert(parse_results.size(), parse_byte(it));
    do @(posedge clk_i); while (!s_axis_tready);
    if (!quiet && $urandom_range(0, 99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_tx();
    foreach (tx_bytes[i]) send_byte(tx_bytes[i]);
  endtask

  task automatic drain_and_idle();
    s_axis_tvalid <= 1'b0;
    while (parse_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_exact(logic v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    m_exact = v;
  endtask

  // ---- output checker ----
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata);
      if (parse_results.size() == 0) report_mismatch("unexpected result", got.part, 0);
      else begin
        want = parse_results.pop_front();
        if (typed_rows.size() != 0) begin
          if (typed_rows[0].chk && (got.part != typed_rows[0].part ||
              got.error != typed_rows[0].err))
            report_mismatch("directed part/error", {got.part, got.error},
                            {typed_rows[0].part, typed_rows[0].err});
          void'(typed_rows.pop_front());
        end
        if (got.part != want.part) report_mismatch("part", got.part, want.part);
        if (got.entry_index != want.entry_index)
          report_mismatch("entry_index", got.entry_index, want.entry_index);
        if (got.field_end != want.field_end)
          report_mismatch("field_end", got.field_end, want.field_end);
        if (got.value_out != want.value_out)
          report_mismatch("value_out", got.value_out, want.value_out);
        if (got.segwit_seen != want.segwit_seen)
          report_mismatch("segwit_seen", got.segwit_seen, want.segwit_seen);
        if (got.done_res != want.done_res)
          report_mismatch("done_res", got.done_res, want.done_res);
        if (got.error != want.error) report_mismatch("error", got.error, want.error);
        if (got.consumed != want.consumed)
          report_mismatch("consumed", got.consumed, want.consumed);
      end
    end
  end

  // output stall
  always @(posedge clk_i) begin
    m_axis_tready <= quiet || ($urandom_range(0, 99) >= 11);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic row_t mk_row(logic first, int unsigned blen, logic [7:0] b,
                                  logic chk, phase_e p, logic err);
    row_t r;
    r.it.first = first; r.it.blen = LenW'(blen); r.it.b = b;
    r.chk = chk; r.part = p; r.err = err;
    return r;
  endfunction

  initial begin
    int unsigned sent;
    logic [7:0] flip;
    clear_parse();
    m_exact = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: no buffer, short, oversize, bad flags, big count, extremes
    dir_rows.insert(dir_rows.size(), mk_row(0, 0, 8'hFF, 1, PH_VERSION, 1));
    dir_rows.insert(dir_rows.size(), mk_row(1, 9, 8'h00, 1, PH_VERSION, 1));
    dir_rows.insert(dir_rows.size(), mk_row(1, 4194305, 8'h00, 1, PH_VERSION, 1));
    dir_rows.insert(dir_rows.size(), mk_row(1, 8388607, 8'hFF, 1, PH_VERSION, 1));
    dir_rows.insert(dir_rows.size(), mk_row(1, 10, 8'h01, 1, PH_VERSION, 0));
    dir_rows.insert(dir_rows.size(), mk_row(0, 0, 8'h00, 0, PH_VERSION, 0));
    dir_rows.insert(dir_rows.size(), mk_row(0, 0, 8'h00, 0, PH_VERSION, 0));
    dir_rows.insert(dir_rows.size(), mk_row(0, 0, 8'h00, 0, PH_VERSION, 0));
    dir_rows.insert(dir_rows.size(), mk_row(0, 0, 8'h00, 1, PH_MARKER, 0));
    dir_rows.insert(dir_rows.size(), mk_row(0, 0, 8'h00, 1, PH_FLAG, 1));    // zero flag
    dir_rows.insert(dir_rows.size(), mk_row(1, 4194304, 8'hFF, 1, PH_VERSION, 0));
    for (int i = 0; i < 3; i++)
      dir_rows.insert(dir_rows.size(), mk_row(0, 0, 8'hFF, 0, PH_VERSION, 0));
    dir_rows.insert(dir_rows.size(), mk_row(0, 0, 8'h00, 1, PH_MARKER, 0));
    dir_rows.insert(dir_rows.size(), mk_row(0, 0, 8'h02, 1, PH_FLAG, 1));    // even flag
    dir_rows.insert(dir_rows.size(), mk_row(1, 10, 8'h02, 0, PH_VERSION, 0));
    for (int i = 0; i < 3; i++)
      dir_rows.insert(dir_rows.size(), mk_row(0, 0, 8'h00, 0, PH_VERSION, 0));
    // six inputs with only five bytes left
    dir_rows.insert(dir_rows.size(), mk_row(0, 0, 8'h06, 1, PH_IN_COUNT, 1));
    dir_rows.insert(dir_rows.size(), mk_row(0, 0, 8'h00, 1, PH_IN_COUNT, 1)); // sticky
    foreach (dir_rows[i]) begin
      typed_rows.insert(typed_rows.size(), dir_rows[i]);
      send_byte(dir_rows[i].it);
    end
    drain_and_idle();

    // random part: phases alternate exact_length, second one unstalled
    sent = 0;
    for (int ph = 0; sent < 500; ph++) begin
      write_exact(ph % 2 == 0 ? 1'b0 : 1'b1);
      quiet = (ph == 1);
      for (int t = 0; t < 2; t++) begin
        build_tx($urandom_range(0, 1), m_exact ? 0 : $urandom_range(0, 3));
        case ($urandom_range(0, 9))
          0: tx_bytes[0].blen = LenW'(tx_bytes.size() - 1);        // truncated
          1: tx_bytes[0].blen = LenW'(tx_bytes.size() + 2);        // trailing / short tx
          2: tx_bytes.insert(tx_bytes.size(),
                             byte_item_t'({1'b0, LenW'(0), 8'($urandom)}));
          3: begin
            flip = 8'($urandom);
            tx_bytes[$urandom_range(0, tx_bytes.size() - 1)].b = flip;  // noise
          end
          default: ;
        endcase
        if (tx_bytes[0].blen < 10) tx_bytes[0].blen = LenW'(10);
        send_tx();
        sent += tx_bytes.size();
      end
      quiet = 1'b0;
      drain_and_idle();
    end
    write_exact(1'b1);
    repeat (2) @(posedge clk_i);
    while (parse_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && parse_results.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
